/* rtl/ble_pkg.sv */
`timescale 1ns / 1ps

package ble_pkg;

    // Channel payloads.
    typedef struct packed {
        logic signed [12:0] adc_sample;
        logic [13:0]        led_load_sum;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  battery_percent;
        logic [12:0] filtered_mv;
        logic        calibrate_request;
    } t_out_item;

    typedef struct packed {
        logic        reg_index;
        logic [9:0]  reg_data;
    } t_cfg_write;

    // Register indexes.
    localparam logic C_REG_CAL_INTERVAL = 1'b0;
    localparam logic C_REG_LOAD_DROP    = 1'b1;

    localparam logic [7:0] C_CAL_INTERVAL_RST = 8'd50;
    localparam logic [9:0] C_LOAD_DROP_RST    = 10'd200;

    localparam int C_LED_COUNT = 16;

    // Shared multiplier operand widths and the reciprocal shift.
    localparam int C_MUL_A_W = 24;
    localparam int C_MUL_B_W = 29;
    localparam int C_PROD_W  = C_MUL_A_W + C_MUL_B_W;
    localparam int C_RCP_SH  = 32;
    localparam int C_QUO_W   = C_PROD_W - C_RCP_SH;

    localparam logic [63:0] C_TWO_POW_SH = 64'd1 << C_RCP_SH;

    // Constant divisors with their truncated reciprocals.
    localparam logic [15:0] C_DIV_ADC = 16'd4095;
    localparam logic [15:0] C_DIV_FLT = 16'd10;
    localparam logic [15:0] C_DIV_200 = 16'd200;
    localparam logic [15:0] C_DIV_500 = 16'd500;

    localparam logic [C_MUL_B_W-1:0] C_RCP_ADC = C_MUL_B_W'(C_TWO_POW_SH / 64'd4095);
    localparam logic [C_MUL_B_W-1:0] C_RCP_FLT = C_MUL_B_W'(C_TWO_POW_SH / 64'd10);
    localparam logic [C_MUL_B_W-1:0] C_RCP_200 = C_MUL_B_W'(C_TWO_POW_SH / 64'd200);
    localparam logic [C_MUL_B_W-1:0] C_RCP_500 = C_MUL_B_W'(C_TWO_POW_SH / 64'd500);

    localparam logic [C_MUL_B_W-1:0] C_SCALE_MV = C_MUL_B_W'(3600);

    // Discharge curve breakpoints in millivolts.
    localparam logic [12:0] C_MV_FULL = 13'd4200;
    localparam logic [12:0] C_MV_HALF = 13'd3700;
    localparam logic [12:0] C_MV_LOW  = 13'd3500;
    localparam logic [12:0] C_MV_CRIT = 13'd3300;
    localparam logic [12:0] C_MV_EMPTY = 13'd2800;

endpackage

/* rtl/ble_intf.sv */
`timescale 1ns / 1ps

interface ble_in_if;
    import ble_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ble_out_if;
    import ble_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ble_cfg_if;
    import ble_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/battery_level_estimator.sv */
`timescale 1ns / 1ps
// A skipped calibration sample has its result valid in the cycle after its own transfer; any
// other sample has the single shared multiplier do the scale, filter, load and curve
// divisions in turn (no filter division for the first sample, none for the curve outside its ends).
// One sample at a time: the next sample can transfer in the same cycle as the previous
// result, and the input is not ready while busy or while a result waits unaccepted.
// Reset: synchronous active-low; clears filter, counter, held level, valid; loads defaults.
module battery_level_estimator #(
    parameter int LED_COUNT = ble_pkg::C_LED_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ble_in_if.sink    i_in,
    ble_cfg_if.sink   i_cfg,
    ble_out_if.source o_out
);
    import ble_pkg::*;

    localparam logic [15:0] D_LOAD = 16'(765 * LED_COUNT);
    localparam logic [C_MUL_B_W-1:0] R_LOAD = C_MUL_B_W'(C_TWO_POW_SH / 64'(D_LOAD));

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_D0    = 4'd2;
    localparam logic [3:0] ST_D1    = 4'd3;
    localparam logic [3:0] ST_D2    = 4'd4;
    localparam logic [3:0] ST_FILT  = 4'd5;
    localparam logic [3:0] ST_LOAD  = 4'd6;
    localparam logic [3:0] ST_VOLT  = 4'd7;
    localparam logic [3:0] ST_CURVE = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [2:0] DV_ADC  = 3'd0;
    localparam logic [2:0] DV_FLT  = 3'd1;
    localparam logic [2:0] DV_LOAD = 3'd2;
    localparam logic [2:0] DV_C200 = 3'd3;
    localparam logic [2:0] DV_C500 = 3'd4;

    // Control state.
    logic [3:0]  r_state, n_state;
    logic        r_oval, n_oval;
    logic [7:0]  r_count, n_count;
    logic        r_primed, n_primed;
    logic [12:0] r_smooth, n_smooth;
    logic [6:0]  r_held, n_held;
    logic [7:0]  r_interval;
    logic [9:0]  r_load_drop;

    // Datapath.
    logic [2:0]            r_div, n_div;
    logic [C_PROD_W-1:0]   r_prod, n_prod;
    logic [C_MUL_A_W-1:0]  r_x, n_x;
    logic [C_QUO_W-1:0]    r_q, n_q;
    logic [12:0]           r_mv, n_mv;
    logic [14:0]           r_drop, n_drop;
    logic [5:0]            r_k, n_k;
    logic [6:0]            r_base, n_base;
    logic [6:0]            r_pct, n_pct;
    logic [13:0]           r_load, n_load;
    t_out_item             r_out, n_out;

    logic [C_MUL_A_W-1:0] mul_a;
    logic [C_MUL_B_W-1:0] mul_b;
    logic [C_PROD_W-1:0]  mul_p;
    logic [15:0]          div_d;
    logic [C_MUL_B_W-1:0] div_r;
    logic [C_MUL_A_W-1:0] rem;
    logic [C_QUO_W-1:0]   q_fix;
    logic [12:0]          volt;
    logic                 out_free;
    logic                 in_fire;
    logic                 skip;

    assign out_free    = !r_oval || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign skip        = r_count >= r_interval;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_oval;
    assign o_out.data  = r_out;

    always_comb begin
        case (r_div)
            DV_ADC:  begin div_d = C_DIV_ADC; div_r = C_RCP_ADC; end
            DV_FLT:  begin div_d = C_DIV_FLT; div_r = C_RCP_FLT; end
            DV_LOAD: begin div_d = D_LOAD;    div_r = R_LOAD;    end
            DV_C200: begin div_d = C_DIV_200; div_r = C_RCP_200; end
            DV_C500: begin div_d = C_DIV_500; div_r = C_RCP_500; end
            default: begin div_d = C_DIV_500; div_r = C_RCP_500; end
        endcase
    end

    // The reciprocal estimate is never above the true quotient and at most one below it,
    // so one compare of the remainder finishes the division.
    assign rem   = r_x - r_prod[C_MUL_A_W-1:0];
    assign q_fix = r_q + C_QUO_W'(rem >= C_MUL_A_W'(div_d));

    assign volt = ({2'b00, r_smooth} >= r_drop) ? (r_smooth - r_drop[12:0]) : 13'd0;

    always_comb begin
        case (r_state)
            ST_SCALE: begin mul_a = C_MUL_A_W'(r_x[11:0]); mul_b = C_SCALE_MV; end
            ST_D0:    begin mul_a = r_prod[C_MUL_A_W-1:0]; mul_b = div_r; end
            ST_D1: begin
                mul_a = C_MUL_A_W'(r_prod[C_PROD_W-1:C_RCP_SH]);
                mul_b = C_MUL_B_W'(div_d);
            end
            ST_LOAD:  begin mul_a = C_MUL_A_W'(r_load_drop); mul_b = C_MUL_B_W'(r_load); end
            ST_CURVE: begin mul_a = r_x; mul_b = C_MUL_B_W'(r_k); end
            default:  begin mul_a = r_x; mul_b = div_r; end
        endcase
    end

    assign mul_p = C_PROD_W'(mul_a) * C_PROD_W'(mul_b);

    always_comb begin
        n_state  = r_state;
        n_oval   = r_oval && !o_out.ready;
        n_count  = r_count;
        n_primed = r_primed;
        n_smooth = r_smooth;
        n_held   = r_held;
        n_div    = r_div;
        n_prod   = r_prod;
        n_x      = r_x;
        n_q      = r_q;
        n_mv     = r_mv;
        n_drop   = r_drop;
        n_k      = r_k;
        n_base   = r_base;
        n_pct    = r_pct;
        n_load   = r_load;
        n_out    = r_out;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (skip) begin
                        n_count = 8'd0;
                        n_out.battery_percent   = r_held;
                        n_out.filtered_mv       = r_smooth;
                        n_out.calibrate_request = 1'b1;
                        n_oval  = 1'b1;
                    end else begin
                        n_count = r_count + 8'd1;
                        n_x     = i_in.data.adc_sample[12] ? '0
                                  : C_MUL_A_W'(i_in.data.adc_sample[11:0]);
                        n_load  = i_in.data.led_load_sum;
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                n_prod  = mul_p;
                n_div   = DV_ADC;
                n_state = ST_D0;
            end
            ST_D0: begin
                n_x     = r_prod[C_MUL_A_W-1:0];
                n_prod  = mul_p;
                n_state = ST_D1;
            end
            ST_D1: begin
                n_q     = r_prod[C_PROD_W-1:C_RCP_SH];
                n_prod  = mul_p;
                n_state = ST_D2;
            end
            ST_D2: begin
                case (r_div)
                    DV_ADC: begin
                        n_mv    = {q_fix[11:0], 1'b0};
                        n_state = ST_FILT;
                    end
                    DV_FLT: begin
                        n_smooth = q_fix[12:0];
                        n_state  = ST_LOAD;
                    end
                    DV_LOAD: begin
                        n_drop  = q_fix[14:0];
                        n_state = ST_VOLT;
                    end
                    default: begin
                        n_pct   = r_base - q_fix[6:0];
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_FILT: begin
                // The first sample seeds the filter directly.
                if (r_primed) begin
                    n_prod  = C_PROD_W'({r_smooth, 3'b000}) + C_PROD_W'(r_smooth)
                              + C_PROD_W'(r_mv);
                    n_div   = DV_FLT;
                    n_state = ST_D0;
                end else begin
                    n_smooth = r_mv;
                    n_primed = 1'b1;
                    n_state  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_prod  = mul_p;
                n_div   = DV_LOAD;
                n_state = ST_D0;
            end
            ST_VOLT: begin
                n_state = ST_CURVE;
                if (volt >= C_MV_FULL) begin
                    n_pct   = 7'd100;
                    n_state = ST_OUT;
                end else if (volt > C_MV_HALF) begin
                    n_x = C_MUL_A_W'(C_MV_FULL - volt);
                    n_k = 6'd50; n_base = 7'd100; n_div = DV_C500;
                end else if (volt > C_MV_LOW) begin
                    n_x = C_MUL_A_W'(C_MV_HALF - volt);
                    n_k = 6'd35; n_base = 7'd50; n_div = DV_C200;
                end else if (volt > C_MV_CRIT) begin
                    n_x = C_MUL_A_W'(C_MV_LOW - volt);
                    n_k = 6'd10; n_base = 7'd15; n_div = DV_C200;
                end else if (volt > C_MV_EMPTY) begin
                    n_x = C_MUL_A_W'(C_MV_CRIT - volt);
                    n_k = 6'd5; n_base = 7'd5; n_div = DV_C500;
                end else begin
                    n_pct   = 7'd0;
                    n_state = ST_OUT;
                end
            end
            ST_CURVE: begin
                n_prod  = mul_p;
                n_state = ST_D0;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_held = r_pct;
                    n_out.battery_percent   = r_pct;
                    n_out.filtered_mv       = r_smooth;
                    n_out.calibrate_request = 1'b0;
                    n_oval  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oval      <= 1'b0;
            r_count     <= 8'd0;
            r_primed    <= 1'b0;
            r_smooth    <= 13'd0;
            r_held      <= 7'd0;
            r_interval  <= C_CAL_INTERVAL_RST;
            r_load_drop <= C_LOAD_DROP_RST;
        end else begin
            r_state  <= n_state;
            r_oval   <= n_oval;
            r_count  <= n_count;
            r_primed <= n_primed;
            r_smooth <= n_smooth;
            r_held   <= n_held;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.reg_index)
                    C_REG_CAL_INTERVAL: r_interval  <= i_cfg.data.reg_data[7:0];
                    C_REG_LOAD_DROP:    r_load_drop <= i_cfg.data.reg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_prod <= n_prod;
        r_x    <= n_x;
        r_q    <= n_q;
        r_mv   <= n_mv;
        r_drop <= n_drop;
        r_k    <= n_k;
        r_base <= n_base;
        r_pct  <= n_pct;
        r_load <= n_load;
        r_out  <= n_out;
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == ST_IDLE))
        else $error("input ready while the sequencer is busy");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_D2) |-> ({1'b0, rem} < {8'b0, div_d, 1'b0}))
        else $error("reciprocal estimate is off by more than one");

    a_skip_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && skip) |=> (r_oval && r_out.calibrate_request
                               && r_out.filtered_mv == $past(r_smooth)))
        else $error("skipped sample did not give a held result");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> (r_out.battery_percent <= 7'd100))
        else $error("battery percent out of range");

    a_count_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_count))
        else $error("sample counter moved without an input transfer");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ble_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 500000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned FULL_LOAD    = 255 * 3 * C_LED_COUNT;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ble_in_if  in_ch ();
    ble_cfg_if cfg_ch ();
    ble_out_if out_ch ();

    battery_level_estimator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predicted copy of the gauge registers and state.
    logic [7:0]  cal_interval = C_CAL_INTERVAL_RST;
    logic [9:0]  drop_mv      = C_LOAD_DROP_RST;
    logic [12:0] est_smoothed_mv = '0;
    logic        est_primed      = 1'b0;
    logic [7:0]  est_count       = '0;
    logic [6:0]  est_held_pct    = '0;

    t_in_item  pending_samples[$];
    t_out_item expected_levels[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold      = 1'b0;
    int unsigned hold_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned err_count    = 0;
    int unsigned samples_sent = 0;
    int unsigned results_seen = 0;
    int unsigned skips_seen   = 0;
    int unsigned settings_run = 0;

    function automatic int unsigned curve_pct(int unsigned mv);
        if (mv >= 4200) return 100;
        if (mv > 3700) return 100 - ((4200 - mv) * 50) / 500;
        if (mv > 3500) return 50 - ((3700 - mv) * 35) / 200;
        if (mv > 3300) return 15 - ((3500 - mv) * 10) / 200;
        if (mv > 2800) return 5 - ((3300 - mv) * 5) / 500;
        return 0;
    endfunction

    // Advances the predicted state by one sample and returns the level it reports.
    function automatic t_out_item predict_level(t_in_item s);
        int unsigned adc;
        int unsigned mv;
        int unsigned acc;
        int unsigned drop;
        int unsigned volt;
        t_out_item   r;
        if (est_count >= cal_interval) begin
            est_count = '0;
            r.calibrate_request = 1'b1;
        end else begin
            est_count = est_count + 8'd1;
            adc = s.adc_sample[12] ? 0 : int'(s.adc_sample[11:0]);
            mv = ((3600 * adc) / 4095) * 2;
            acc = est_smoothed_mv;
            acc = est_primed ? (acc * 9 + mv) / 10 : mv;
            est_primed = 1'b1;
            est_smoothed_mv = 13'(acc);
            drop = drop_mv;
            drop = (drop * s.led_load_sum) / FULL_LOAD;
            volt = (acc >= drop) ? acc - drop : 0;
            est_held_pct = 7'(curve_pct(volt));
            r.calibrate_request = 1'b0;
        end
        r.battery_percent = est_held_pct;
        r.filtered_mv = est_smoothed_mv;
        return r;
    endfunction

    task automatic report(string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // Sample driver: a new item goes out only once the previous one has transferred.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_samples.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) begin
            hold_count <= hold_count + 1;
        end else begin
            hold_count <= 0;
        end
    end

    // Watches every channel: register writes update the prediction, sample transfers
    // queue an expected level, result transfers are checked against the oldest one.
    always @(posedge i_clk) begin
        t_out_item exp_lvl;
        t_out_item got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.reg_index)
                    C_REG_CAL_INTERVAL: cal_interval = cfg_ch.data.reg_data[7:0];
                    C_REG_LOAD_DROP: drop_mv = cfg_ch.data.reg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_levels.push_back(predict_level(in_ch.data));
                samples_sent++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                results_seen++;
                if (got.calibrate_request) skips_seen++;
                if (expected_levels.size() == 0) begin
                    report($sformatf("unexpected result pct=%0d mv=%0d cal=%0b",
                        got.battery_percent, got.filtered_mv, got.calibrate_request));
                end else begin
                    exp_lvl = expected_levels.pop_front();
                    if (got.battery_percent !== exp_lvl.battery_percent)
                        report($sformatf("battery_percent got %0d expected %0d",
                            got.battery_percent, exp_lvl.battery_percent));
                    if (got.filtered_mv !== exp_lvl.filtered_mv)
                        report($sformatf("filtered_mv got %0d expected %0d",
                            got.filtered_mv, exp_lvl.filtered_mv));
                    if (got.calibrate_request !== exp_lvl.calibrate_request)
                        report($sformatf("calibrate_request got %0b expected %0b",
                            got.calibrate_request, exp_lvl.calibrate_request));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout with %0d samples pending and %0d results outstanding.",
                pending_samples.size(), expected_levels.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_sample(int adc, int unsigned load);
        t_in_item s;
        s.adc_sample = 13'(adc);
        s.led_load_sum = 14'(load);
        pending_samples.push_back(s);
    endtask

    // Mostly steady battery levels with small jitter, so the filter settles on every
    // segment of the curve; the rest is raw noise and jumps to the rails.
    task automatic queue_samples(int unsigned n);
        int unsigned done;
        int unsigned len;
        int unsigned level;
        int unsigned kind;
        int unsigned load;
        int          adc;
        done = 0;
        while (done < n) begin
            kind = $urandom_range(9);
            level = $urandom_range(2600, 4400);
            len = (kind <= 6) ? $urandom_range(5, 40) : $urandom_range(1, 5);
            for (int k = 0; k < len && done < n; k++) begin
                if (kind <= 6) begin
                    adc = int'(level * 4095 / 7200) + int'($urandom_range(16)) - 8;
                end else if (kind == 9) begin
                    adc = $urandom_range(1) ? 4095 : -int'($urandom_range(1, 4096));
                end else begin
                    adc = $urandom_range(8191);
                end
                case ($urandom_range(3))
                    0: load = 0;
                    1: load = $urandom_range(2000);
                    2: load = $urandom_range(FULL_LOAD);
                    default: load = $urandom_range(16383);
                endcase
                if (kind == 7 || kind == 8) load = $urandom_range(16383);
                push_sample(adc, load);
                done++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || expected_levels.size() != 0 || in_ch.valid);
    endtask

    task automatic write_reg(logic idx, logic [9:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{reg_index: idx, reg_data: val};
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(logic [9:0] interval, logic [9:0] drop, int unsigned tx,
                             int unsigned rx, int unsigned n);
        wait_idle();
        write_reg(C_REG_CAL_INTERVAL, interval);
        write_reg(C_REG_LOAD_DROP, drop);
        settings_run++;
        @(posedge i_clk);
        tx_idle_pct <= tx;
        rx_stall_pct <= rx;
        queue_samples(n);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset settings: seeding, rails, negative
        // clamping, loads at and above full scale.
        push_sample(2389, 0);
        push_sample(4095, 0);
        push_sample(-4096, 0);
        push_sample(-1, 16383);
        push_sample(0, FULL_LOAD);
        push_sample(1, 0);
        push_sample(4095, 16383);
        push_sample(4095, FULL_LOAD);
        push_sample(4094, 1);
        push_sample(2048, 8191);
        for (int k = 0; k < 6; k++) push_sample(2389, 0);
        for (int k = 0; k < 4; k++) push_sample(2055, 6120);
        for (int k = 0; k < 4; k++) push_sample(1600, 3000);
        queue_samples(300);

        run_phase(10'd1, 10'd1023, 47, 0, 200);
        run_phase(10'd255, 10'd1000, 0, 47, 300);
        // Interval lowered below the running count: the next sample is skipped.
        run_phase(10'd5, 10'd0, 33, 33, 200);
        run_phase(10'd0, 10'd512, 0, 0, 30);
        // Bits above the interval field are dropped, leaving 255.
        run_phase(10'h3FF, 10'd700, 33, 33, 250);

        // Receiver stops for a long stretch while samples keep coming.
        run_phase(10'd20, 10'd300, 0, 0, 150);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        do @(negedge i_clk);
        while (hold_count < HOLD_CYCLES);
        @(posedge i_clk);
        rx_hold <= 1'b0;

        run_phase(10'd3, 10'd100, 47, 47, 100);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Checked %0d gauge results (%0d calibration skips) from %0d samples",
            results_seen, skips_seen, samples_sent);
        $display("across %0d register settings, with sender gaps and receiver stalls.",
            settings_run + 1);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
